/* rtl/bcsq_pkg.sv */
// Shared constants and codes for the byte chi-square uniformity test.
package bcsq_pkg;

   localparam int BIN_W       = 8;
   localparam int NUM_BINS    = 1 << BIN_W;
   localparam int IDX_W       = BIN_W + 1;
   localparam int COUNT_W     = 21;
   localparam int MAX_SAMPLES = 1048576;
   localparam int THR_W       = 17;
   localparam int SUM_W       = 56;
   localparam int DEV_W       = COUNT_W + BIN_W;
   localparam int SQ_W        = 2 * DEV_W;
   localparam int PROD_W      = THR_W + COUNT_W;
   localparam int LEVEL_W     = 2;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [THR_W-1:0] THR_LOW_RESET  = THR_W'(72680);
   localparam logic [THR_W-1:0] THR_MID_RESET  = THR_W'(74819);
   localparam logic [THR_W-1:0] THR_HIGH_RESET = THR_W'(78750);

   // register indexes, byte address = 4 * index
   localparam logic [1:0] REG_THR_LOW  = 2'd0;
   localparam logic [1:0] REG_THR_MID  = 2'd1;
   localparam logic [1:0] REG_THR_HIGH = 2'd2;

   // verdict codes
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_FAIL = 2'd3;

endpackage

/* rtl/bcsq_req_if.sv */
// Request channel: one byte sample and its end-of-run mark.
interface bcsq_req_if import bcsq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [BIN_W-1:0] sample;
   logic             last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/bcsq_rsp_if.sv */
// Response channel: verdict of one run.
interface bcsq_rsp_if import bcsq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] verdict_level;
   logic               passed;
   logic [SUM_W-1:0]   deviation_sum;
   logic [COUNT_W-1:0] sample_total;

   modport source (output valid, output verdict_level, output passed,
                   output deviation_sum, output sample_total, input ready);
   modport sink   (input valid, input verdict_level, input passed,
                   input deviation_sum, input sample_total, output ready);
endinterface

/* rtl/bcsq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bcsq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/byte_chi_square_uniformity_test.sv */
// Top level of the byte chi-square uniformity test.
//
// Usage
//   Requests carry one byte sample each; a request with last set closes the
//   run. Each counted sample bumps its bin in a 256 x 21 histogram RAM. The
//   end pass then walks the 256 bins and sums (256*f - N)^2, compares the
//   sum against each Q.8 threshold times N and returns one response.
//   Throughput: one sample per cycle while a run is being collected
//   (read-modify-write on the RAM, same-bin back-to-back forwarded).
//   The response turns valid once the end pass has read all 256 bins,
//   drained its subtract/square/sum pipeline and found the response
//   register free. Request ready stays low from the cycle after the last
//   sample until the response is loaded.
//   Samples beyond capacity (2^20 per run) are dropped; an empty run fails.
//   Reset clears the bin valid flags, the count and both channels at once
//   (no clearing sweep); thresholds return to their default values.
//   Stall: while the response waits, new samples are still taken; a second
//   end pass holds its result until the previous response is taken.
//   Thresholds are written over the APB port at 0x0, 0x4, 0x8.
module byte_chi_square_uniformity_test import bcsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bcsq_req_if.sink              req_ch,
   bcsq_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // threshold registers
   logic [THR_W-1:0] thr_low_ff, thr_low_in;
   logic [THR_W-1:0] thr_mid_ff, thr_mid_in;
   logic [THR_W-1:0] thr_high_ff, thr_high_in;

   // run state
   logic [COUNT_W-1:0]  run_count_ff, run_count_in;
   logic [NUM_BINS-1:0] bin_valid_ff, bin_valid_in;

   // sample pipeline: stage 1 holds the bin being incremented
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_inc_ff, s1_inc_in;
   logic               s1_last_ff, s1_last_in;
   logic [BIN_W-1:0]   s1_addr_ff, s1_addr_in;
   logic               wb_valid_ff, wb_valid_in;
   logic [BIN_W-1:0]   wb_addr_ff, wb_addr_in;
   logic [COUNT_W-1:0] wb_data_ff, wb_data_in;

   // end pass pipeline
   logic [IDX_W-1:0]   eval_idx_ff, eval_idx_in;
   logic               e1_valid_ff, e1_valid_in;
   logic [BIN_W-1:0]   e1_addr_ff, e1_addr_in;
   logic               e2_valid_ff, e2_valid_in;
   logic [DEV_W-1:0]   dev_ff, dev_in;
   logic               e3_valid_ff, e3_valid_in;
   logic [SUM_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PROD_W-1:0]  lim_low_ff, lim_mid_ff, lim_high_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               passed_ff, passed_in;
   logic [SUM_W-1:0]   dsum_ff, dsum_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   // RAM port
   logic               ram_wr_en;
   logic [BIN_W-1:0]   ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic [BIN_W-1:0]   ram_rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;

   logic               req_ready;
   logic               req_accept;
   logic               count_ok;
   logic               csr_write;
   logic               eval_issue;
   logic               load_rsp;
   logic [COUNT_W-1:0] cur_count;
   logic [COUNT_W-1:0] bin_f;
   logic [DEV_W-1:0]   scaled;
   logic [DEV_W-1:0]   n_ext;
   logic [SQ_W-1:0]    sq_full;

   bcsq_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_BINS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // --- handshakes ---
   // no new sample once a last sample sits in stage 1
   assign req_ready    = (state_ff == ST_ACCUM) && !(s1_valid_ff && s1_last_ff);
   assign req_ch.ready = req_ready;
   assign req_accept   = req_ch.valid && req_ready;
   assign count_ok     = run_count_ff < COUNT_W'(MAX_SAMPLES);

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_THR_LOW:  prdata = CSR_DATA_W'(thr_low_ff);
         REG_THR_MID:  prdata = CSR_DATA_W'(thr_mid_ff);
         REG_THR_HIGH: prdata = CSR_DATA_W'(thr_high_ff);
         default:      prdata = '0;
      endcase
   end

   // --- increment path: forward the write of the previous cycle ---
   always_comb begin
      if (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) begin
         cur_count = wb_data_ff;
      end else if (bin_valid_ff[s1_addr_ff]) begin
         cur_count = ram_rd_data;
      end else begin
         cur_count = '0;
      end
   end

   assign ram_wr_en   = s1_valid_ff && s1_inc_ff;
   assign ram_wr_addr = s1_addr_ff;
   assign ram_wr_data = cur_count + COUNT_W'(1);

   // --- end pass datapath ---
   assign eval_issue  = (state_ff == ST_EVAL) && !eval_idx_ff[BIN_W];
   assign ram_rd_addr = (state_ff == ST_EVAL) ? eval_idx_ff[BIN_W-1:0] : req_ch.sample;

   assign bin_f   = bin_valid_ff[e1_addr_ff] ? ram_rd_data : '0;
   assign scaled  = {bin_f, {BIN_W{1'b0}}};
   assign n_ext   = DEV_W'(run_count_ff);
   assign dev_in  = (scaled >= n_ext) ? (scaled - n_ext) : (n_ext - scaled);
   assign sq_full = SQ_W'(dev_ff) * SQ_W'(dev_ff);
   assign sq_in   = sq_full[SUM_W-1:0];

   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // verdict: first threshold passed, in order low, mid, high
   always_comb begin
      if (run_count_ff == '0) begin
         level_in = LEVEL_FAIL;
      end else if (sum_ff <= SUM_W'(lim_low_ff)) begin
         level_in = LEVEL_LOW;
      end else if (sum_ff <= SUM_W'(lim_mid_ff)) begin
         level_in = LEVEL_MID;
      end else if (sum_ff <= SUM_W'(lim_high_ff)) begin
         level_in = LEVEL_HIGH;
      end else begin
         level_in = LEVEL_FAIL;
      end
      passed_in = (level_in != LEVEL_FAIL);
      dsum_in   = sum_ff;
      total_in  = run_count_ff;
   end

   // --- next-state logic ---
   always_comb begin
      state_in     = state_ff;
      thr_low_in   = thr_low_ff;
      thr_mid_in   = thr_mid_ff;
      thr_high_in  = thr_high_ff;
      run_count_in = run_count_ff;
      bin_valid_in = bin_valid_ff;
      eval_idx_in  = eval_idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_write) begin
         unique case (paddr[3:2])
            REG_THR_LOW:  thr_low_in  = pwdata[THR_W-1:0];
            REG_THR_MID:  thr_mid_in  = pwdata[THR_W-1:0];
            REG_THR_HIGH: thr_high_in = pwdata[THR_W-1:0];
            default:      ;
         endcase
      end

      s1_valid_in = req_accept;
      s1_inc_in   = count_ok;
      s1_last_in  = req_ch.last;
      s1_addr_in  = req_ch.sample;
      if (req_accept && count_ok) begin
         run_count_in = run_count_ff + COUNT_W'(1);
      end

      wb_valid_in = ram_wr_en;
      wb_addr_in  = ram_wr_addr;
      wb_data_in  = ram_wr_data;
      if (ram_wr_en) begin
         bin_valid_in[ram_wr_addr] = 1'b1;
      end

      e1_valid_in = eval_issue;
      e1_addr_in  = eval_idx_ff[BIN_W-1:0];
      e2_valid_in = e1_valid_ff;
      e3_valid_in = e2_valid_ff;
      if (eval_issue) begin
         eval_idx_in = eval_idx_ff + IDX_W'(1);
      end
      if (e3_valid_ff) begin
         sum_in = sum_ff + sq_ff;
      end

      unique case (state_ff)
         ST_ACCUM: begin
            if (s1_valid_ff && s1_last_ff) begin
               state_in    = ST_EVAL;
               eval_idx_in = '0;
               sum_in      = '0;
            end
         end
         ST_EVAL: begin
            if (eval_idx_ff[BIN_W] && !e1_valid_ff && !e2_valid_ff && !e3_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in     = ST_ACCUM;
               rsp_valid_in = 1'b1;
               run_count_in = '0;
               bin_valid_in = '0;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // --- registers ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         thr_low_ff   <= THR_LOW_RESET;
         thr_mid_ff   <= THR_MID_RESET;
         thr_high_ff  <= THR_HIGH_RESET;
         run_count_ff <= '0;
         bin_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         eval_idx_ff  <= '0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_low_ff   <= thr_low_in;
         thr_mid_ff   <= thr_mid_in;
         thr_high_ff  <= thr_high_in;
         run_count_ff <= run_count_in;
         bin_valid_ff <= bin_valid_in;
         s1_valid_ff  <= s1_valid_in;
         wb_valid_ff  <= wb_valid_in;
         eval_idx_ff  <= eval_idx_in;
         e1_valid_ff  <= e1_valid_in;
         e2_valid_ff  <= e2_valid_in;
         e3_valid_ff  <= e3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_inc_ff   <= s1_inc_in;
      s1_last_ff  <= s1_last_in;
      s1_addr_ff  <= s1_addr_in;
      wb_addr_ff  <= wb_addr_in;
      wb_data_ff  <= wb_data_in;
      e1_addr_ff  <= e1_addr_in;
      dev_ff      <= dev_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      // N is stable for the whole end pass
      lim_low_ff  <= PROD_W'(thr_low_ff) * PROD_W'(run_count_ff);
      lim_mid_ff  <= PROD_W'(thr_mid_ff) * PROD_W'(run_count_ff);
      lim_high_ff <= PROD_W'(thr_high_ff) * PROD_W'(run_count_ff);
      if (load_rsp) begin
         level_ff  <= level_in;
         passed_ff <= passed_in;
         dsum_ff   <= dsum_in;
         total_ff  <= total_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.verdict_level = level_ff;
   assign rsp_ch.passed        = passed_ff;
   assign rsp_ch.deviation_sum = dsum_ff;
   assign rsp_ch.sample_total  = total_ff;

endmodule
